### design/hctbp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the Huffman code table bit packer.
// No dependencies; imported by the packing step and the top level.
package hctbp_pkg;

    localparam int CODE_W    = 32;
    localparam int LEN_FW    = 6;
    localparam int BYTE_BITS = 8;
    localparam int CNT_W     = 4;

    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_ENCODE = 2'd1;
    localparam logic [1:0] REQ_FLUSH  = 2'd2;

    // Working state of the packing loop.
    typedef struct packed {
        logic [CODE_W-1:0] cw;     // remaining codeword bits, left aligned
        logic [7:0]        pbuf;   // packing buffer
        logic [CNT_W-1:0]  cnt;    // bits held in pbuf, 0 to 8
        logic [LEN_FW-1:0] rem;    // codeword bits still to move
    } pack_state_t;

endpackage

### design/huffman_code_table_bit_packer_unit.sv
`timescale 1ns / 1ps
// Top level of the Huffman code table bit packer: codeword table, sequencer
// and output register. Depends on hctbp_pkg, hctbp_ram and hctbp_shifter.
//
// Usage. Requests arrive on the s_axis channel: tuser carries the request
// kind (load entry, encode symbol, flush), tdata the symbol, the codeword and
// its length. Results leave on the m_axis channel: tdata carries the packed
// byte and its valid bit count, tuser flags a symbol without a table entry,
// and tlast marks the final result of a request.
//
// The block works on one request at a time; s_axis_tready is high only while
// the sequencer is idle. A valid load is written to the table on its transfer;
// a flush sends the buffer from the single-result state, and an encode of a
// symbol without an entry reads the table and then sends an error result. A
// good encode reads the table, then takes packing steps through the shared
// shifter (up to eight bits into the buffer, or one full byte sent), then finishes.
// A full byte is held until the next bit arrives, so it can leave with a later
// request. The output register lets the next request in while a result waits;
// a stalled receiver holds the sequencer at the next result it must send.
// Reset empties the buffer and marks every table entry as empty.
module huffman_code_table_bit_packer_unit
    import hctbp_pkg::*;
#(
    parameter int SYMBOLS = 256,
    parameter int MAX_LEN = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // symbol[7:0], code_bits[39:8], code_len[45:40]
    input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // out_byte[7:0], out_bits[11:8]
    output logic        m_axis_tuser,   // error[0]
    output logic        m_axis_tlast
);

    localparam int LEN_LIM = (MAX_LEN < CODE_W) ? MAX_LEN : CODE_W;
    localparam int LEN_W   = $clog2(LEN_LIM + 1);
    localparam int SYM_W   = $clog2(SYMBOLS);
    localparam int ENT_W   = CODE_W + LEN_W;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_LOOK   = 2'd1;
    localparam logic [1:0] S_PACK   = 2'd2;
    localparam logic [1:0] S_SINGLE = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [SYMBOLS-1:0] valid_reg;
    logic [SYM_W-1:0]   sym_reg, sym_next;
    logic               range_reg, range_next;
    logic               single_err_reg, single_err_next;
    pack_state_t        pk_reg, pk_next, pk_step;

    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_byte_reg, out_byte_next;
    logic [CNT_W-1:0]   out_bits_reg, out_bits_next;
    logic               out_err_reg, out_err_next;
    logic               out_last_reg, out_last_next;

    logic [1:0]         in_req;
    logic [7:0]         in_sym;
    logic [CODE_W-1:0]  in_code;
    logic [LEN_FW-1:0]  in_len;
    logic               in_range;
    logic               in_xfer;
    logic               ram_we;
    logic [SYM_W-1:0]   ram_addr;
    logic [ENT_W-1:0]   ram_wdata, ram_rdata;
    logic [LEN_FW-1:0]  entry_len;
    logic               out_free;

    assign in_req   = s_axis_tuser;
    assign in_sym   = s_axis_tdata[7:0];
    assign in_code  = s_axis_tdata[39:8];
    assign in_len   = s_axis_tdata[45:40];
    assign in_range = ({1'b0, in_sym} < 9'(SYMBOLS));

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // Table write on a load transfer; the same port reads for an encode.
    assign ram_we    = in_xfer && (in_req == REQ_LOAD) && in_range
                       && ({1'b0, in_len} <= 7'(LEN_LIM));
    assign ram_addr  = in_sym[SYM_W-1:0];
    assign ram_wdata = {in_code, in_len[LEN_W-1:0]};

    hctbp_ram #(
        .WIDTH (ENT_W),
        .DEPTH (SYMBOLS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    hctbp_shifter u_shifter (
        .cur (pk_reg),
        .nxt (pk_step)
    );

    // An entry never written since reset reads as empty.
    assign entry_len = valid_reg[sym_reg]
                       ? {{(LEN_FW-LEN_W){1'b0}}, ram_rdata[LEN_W-1:0]}
                       : '0;

    assign out_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next      = state_reg;
        sym_next        = sym_reg;
        range_next      = range_reg;
        single_err_next = single_err_reg;
        pk_next         = pk_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_byte_next   = out_byte_reg;
        out_bits_next   = out_bits_reg;
        out_err_next    = out_err_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    case (in_req)
                        REQ_ENCODE:
                        begin
                            sym_next   = in_sym[SYM_W-1:0];
                            range_next = in_range;
                            state_next = S_LOOK;
                        end
                        REQ_FLUSH:
                        begin
                            single_err_next = 1'b0;
                            state_next      = S_SINGLE;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_LOOK:
            begin
                if (!range_reg || (entry_len == '0))
                begin
                    single_err_next = 1'b1;
                    state_next      = S_SINGLE;
                end
                else
                begin
                    pk_next.cw  = ram_rdata[ENT_W-1:LEN_W] << (LEN_FW'(CODE_W) - entry_len);
                    pk_next.rem = entry_len;
                    state_next  = S_PACK;
                end
            end
            S_PACK:
            begin
                if (pk_reg.rem == '0)
                begin
                    state_next = S_IDLE;
                end
                else if (pk_reg.cnt == CNT_W'(BYTE_BITS))
                begin
                    // A full byte goes out only now that another bit follows.
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = pk_reg.pbuf;
                        out_bits_next  = CNT_W'(BYTE_BITS);
                        out_err_next   = 1'b0;
                        out_last_next  = (pk_reg.rem <= LEN_FW'(BYTE_BITS));
                        pk_next.pbuf   = '0;
                        pk_next.cnt    = '0;
                    end
                end
                else
                begin
                    pk_next = pk_step;
                end
            end
            S_SINGLE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_err_next   = single_err_reg;
                    out_last_next  = 1'b1;
                    if (single_err_reg)
                    begin
                        out_byte_next = '0;
                        out_bits_next = '0;
                    end
                    else
                    begin
                        out_byte_next = pk_reg.pbuf;
                        out_bits_next = pk_reg.cnt;
                        pk_next.pbuf  = '0;
                        pk_next.cnt   = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            pk_reg         <= '0;
            out_valid_reg  <= 1'b0;
            single_err_reg <= 1'b0;
            range_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pk_reg         <= pk_next;
            out_valid_reg  <= out_valid_next;
            single_err_reg <= single_err_next;
            range_reg      <= range_next;
            if (ram_we)
            begin
                valid_reg[ram_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg      <= sym_next;
        out_byte_reg <= out_byte_next;
        out_bits_reg <= out_bits_next;
        out_err_reg  <= out_err_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0, out_bits_reg, out_byte_reg};
    assign m_axis_tuser  = out_err_reg;
    assign m_axis_tlast  = out_last_reg;

    // The buffer never holds more than one byte.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pk_reg.cnt <= CNT_W'(BYTE_BITS))
        else $error("bit count above eight");

    // A full byte waiting on a busy output register is not overwritten.
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PACK && pk_reg.cnt == CNT_W'(BYTE_BITS)
         && pk_reg.rem != '0 && !out_free) |=> $stable(pk_reg.pbuf))
        else $error("held byte changed while the output was stalled");

    // An error result is a lone, empty result.
    a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && m_axis_tdata[11:0] == 12'd0))
        else $error("malformed error result");

    // Only full bytes are followed by further results of the same request.
    a_mid_full: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[11:8] == 4'd8))
        else $error("partial byte in the middle of a request");

endmodule

### design/hctbp_ram.sv
`timescale 1ns / 1ps
// Generic single-port RAM with registered read data.
// No dependencies.
module hctbp_ram #(
    parameter int WIDTH = 38,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

### design/hctbp_shifter.sv
`timescale 1ns / 1ps
// One packing step: moves as many codeword bits as fit into the byte buffer.
// Depends on hctbp_pkg.
module hctbp_shifter
    import hctbp_pkg::*;
(
    input  pack_state_t cur,
    output pack_state_t nxt
);

    logic [CNT_W-1:0] space;
    logic [CNT_W-1:0] take_n;
    logic [7:0]       take_bits;

    always_comb
    begin
        space = CNT_W'(BYTE_BITS) - cur.cnt;
        if ({{(LEN_FW-CNT_W){1'b0}}, space} > cur.rem)
        begin
            take_n = cur.rem[CNT_W-1:0];
        end
        else
        begin
            take_n = space;
        end
        // The top bits of the left-aligned codeword, right aligned.
        take_bits = cur.cw[CODE_W-1 -: 8] >> (CNT_W'(BYTE_BITS) - take_n);

        nxt.cw   = cur.cw << take_n;
        nxt.pbuf = (cur.pbuf << take_n) | take_bits;
        nxt.cnt  = cur.cnt + take_n;
        nxt.rem  = cur.rem - {{(LEN_FW-CNT_W){1'b0}}, take_n};
    end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for huffman_code_table_bit_packer_unit: a directed table, then
// random requests under changing stream back-pressure, checked against a local model and typed expectations.
// Depends on hctbp_pkg and the design files of the packer unit.
module tb
    import hctbp_pkg::*;
();

    localparam int         SYM_COUNT    = 256;
    localparam int         LEN_LIMIT    = 32;
    localparam logic [1:0] REQ_UNUSED   = 2'd3;
    localparam int         DIR_N        = 23;
    localparam int         PHASE_ITEMS  = 28;
    localparam int         TAIL_CYCLES  = 60;
    localparam int         CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [3:0] out_bits;
        logic       err;
        logic       last;
    } packer_result_t;

    typedef struct packed {
        logic [1:0]        req;
        logic [7:0]        sym;
        logic [CODE_W-1:0] code;
        logic [LEN_FW-1:0] len;
        logic              typed;
        packer_result_t    want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;   // symbol[7:0], code_bits[39:8], code_len[45:40]
    logic [1:0]  s_axis_tuser = '0;   // req_type[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // out_byte[7:0], out_bits[11:8]
    logic        m_axis_tuser;        // error[0]
    logic        m_axis_tlast;

    // Shadow copy of the codeword table and the packing buffer.
    logic [CODE_W-1:0] shadow_code [SYM_COUNT];
    logic [LEN_FW-1:0] shadow_len  [SYM_COUNT];
    logic [7:0]        shadow_buf;
    logic [3:0]        shadow_cnt;

    packer_result_t    expected_bytes [$];
    stim_row_t         dir_rows [0:DIR_N-1];
    int                src_idle_pct = 12;
    int                sink_stall_pct = 53;
    int                fail_count = 0;
    int                cycle_count = 0;

    huffman_code_table_bit_packer_unit #(
        .SYMBOLS(SYM_COUNT),
        .MAX_LEN(LEN_LIMIT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always #1 clk = ~clk;

    // Works out the bytes that one accepted request pushes out and queues them.
    task automatic pack_predict(input logic [1:0] req, input logic [7:0] sym,
                                input logic [CODE_W-1:0] code, input logic [LEN_FW-1:0] len);
        int             first;
        int             k;
        packer_result_t r;
        first = expected_bytes.size();
        case (req)
            REQ_LOAD:
            begin
                if (int'(sym) < SYM_COUNT && int'(len) <= LEN_LIMIT && int'(len) <= CODE_W)
                begin
                    shadow_code[sym] = code;
                    shadow_len[sym]  = len;
                end
            end
            REQ_ENCODE:
            begin
                if (int'(sym) >= SYM_COUNT || shadow_len[sym] == '0)
                begin
                    expected_bytes.push_back('{8'd0, 4'd0, 1'b1, 1'b1});
                end
                else
                begin
                    for (k = int'(shadow_len[sym]) - 1; k >= 0; k--)
                    begin
                        // A full buffer leaves only when the next bit needs room.
                        if (int'(shadow_cnt) >= BYTE_BITS)
                        begin
                            expected_bytes.push_back('{shadow_buf, 4'(BYTE_BITS), 1'b0, 1'b0});
                            shadow_buf = '0;
                            shadow_cnt = '0;
                        end
                        shadow_buf = {shadow_buf[6:0], shadow_code[sym][k]};
                        shadow_cnt = shadow_cnt + 4'd1;
                    end
                    if (expected_bytes.size() > first)
                    begin
                        r = expected_bytes.pop_back();
                        r.last = 1'b1;
                        expected_bytes.push_back(r);
                    end
                end
            end
            REQ_FLUSH:
            begin
                expected_bytes.push_back('{shadow_buf, shadow_cnt, 1'b0, 1'b1});
                shadow_buf = '0;
                shadow_cnt = '0;
            end
            default:
            begin
            end
        endcase
    endtask

    // Presents one request after a random gap and returns at the edge of its transfer.
    task automatic send_request(input logic [1:0] req, input logic [7:0] sym,
                                input logic [CODE_W-1:0] code, input logic [LEN_FW-1:0] len);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {2'b00, len, code, sym};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pack_predict(req, sym, code, len);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_bytes.size() != 0)
            @(posedge clk);
    endtask

    // Result side: check each transfer against the oldest expectation, then pick the next stall.
    always @(posedge clk)
    begin
        packer_result_t got;
        packer_result_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = '{m_axis_tdata[7:0], m_axis_tdata[11:8], m_axis_tuser, m_axis_tlast};
                if (expected_bytes.size() == 0)
                begin
                    $error("unexpected result: out_byte %0h out_bits %0d error %0b last %0b",
                           got.out_byte, got.out_bits, got.err, got.last);
                    fail_count++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (got.out_byte !== want.out_byte)
                    begin
                        $error("out_byte: expected %0h, actual %0h", want.out_byte, got.out_byte);
                        fail_count++;
                    end
                    if (got.out_bits !== want.out_bits)
                    begin
                        $error("out_bits: expected %0d, actual %0d", want.out_bits, got.out_bits);
                        fail_count++;
                    end
                    if (got.err !== want.err)
                    begin
                        $error("error: expected %0b, actual %0b", want.err, got.err);
                        fail_count++;
                    end
                    if (got.last !== want.last)
                    begin
                        $error("last: expected %0b, actual %0b", want.last, got.last);
                        fail_count++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("huffman_code_table_bit_packer_unit regression: fail");
        $finish;
    end

    initial
    begin
        logic [1:0]        req;
        logic [7:0]        sym;
        logic [CODE_W-1:0] code;
        logic [LEN_FW-1:0] len;
        packer_result_t    r;
        int                pick;
        int                ph;
        int                sent;

        foreach (shadow_len[i])
        begin
            shadow_code[i] = '0;
            shadow_len[i]  = '0;
        end
        shadow_buf = '0;
        shadow_cnt = '0;

        // Typed expectations only where the answer is plain; the rest come from the model.
        dir_rows = '{
            '{REQ_FLUSH,  8'd0,   32'h0000_0000, 6'd0,  1'b1, '{8'h00, 4'd0, 1'b0, 1'b1}},
            '{REQ_ENCODE, 8'd0,   32'h0000_0000, 6'd0,  1'b1, '{8'h00, 4'd0, 1'b1, 1'b1}},
            '{REQ_ENCODE, 8'd255, 32'h0000_0000, 6'd0,  1'b1, '{8'h00, 4'd0, 1'b1, 1'b1}},
            '{REQ_LOAD,   8'd0,   32'h0000_0001, 6'd1,  1'b0, '0},
            '{REQ_LOAD,   8'd1,   32'hFFFF_FFA5, 6'd8,  1'b0, '0},
            '{REQ_LOAD,   8'd255, 32'hFFFF_FFFF, 6'd32, 1'b0, '0},
            '{REQ_LOAD,   8'd3,   32'h0000_0000, 6'd32, 1'b0, '0},
            '{REQ_LOAD,   8'd2,   32'hFFFF_FFFF, 6'd33, 1'b0, '0},
            '{REQ_ENCODE, 8'd2,   32'h0000_0000, 6'd0,  1'b1, '{8'h00, 4'd0, 1'b1, 1'b1}},
            '{REQ_LOAD,   8'd0,   32'hDEAD_BEEF, 6'd63, 1'b0, '0},
            '{REQ_UNUSED, 8'd255, 32'hFFFF_FFFF, 6'd63, 1'b0, '0},
            '{REQ_ENCODE, 8'd1,   32'h0000_0000, 6'd0,  1'b0, '0},
            '{REQ_ENCODE, 8'd0,   32'h0000_0000, 6'd0,  1'b0, '0},
            '{REQ_FLUSH,  8'd0,   32'h0000_0000, 6'd0,  1'b1, '{8'h01, 4'd1, 1'b0, 1'b1}},
            '{REQ_FLUSH,  8'd0,   32'h0000_0000, 6'd0,  1'b1, '{8'h00, 4'd0, 1'b0, 1'b1}},
            '{REQ_ENCODE, 8'd255, 32'h0000_0000, 6'd0,  1'b0, '0},
            '{REQ_ENCODE, 8'd3,   32'h0000_0000, 6'd0,  1'b0, '0},
            '{REQ_ENCODE, 8'd0,   32'h0000_0000, 6'd0,  1'b0, '0},
            '{REQ_FLUSH,  8'd0,   32'h0000_0000, 6'd0,  1'b0, '0},
            '{REQ_LOAD,   8'd0,   32'h0000_0000, 6'd0,  1'b0, '0},
            '{REQ_ENCODE, 8'd0,   32'h0000_0000, 6'd0,  1'b1, '{8'h00, 4'd0, 1'b1, 1'b1}},
            '{REQ_ENCODE, 8'd1,   32'h0000_0000, 6'd0,  1'b0, '0},
            '{REQ_FLUSH,  8'd0,   32'h0000_0000, 6'd0,  1'b1, '{8'hA5, 4'd8, 1'b0, 1'b1}}
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            send_request(dir_rows[i].req, dir_rows[i].sym, dir_rows[i].code, dir_rows[i].len);
            if (dir_rows[i].typed)
            begin
                r = expected_bytes.pop_back();
                expected_bytes.push_back(dir_rows[i].want);
            end
        end

        for (ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    src_idle_pct   = 12;
                    sink_stall_pct = 53;
                end
                1:
                begin
                    src_idle_pct   = 53;
                    sink_stall_pct = 12;
                end
                default:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
            endcase
            // Hold the request side until the result stream is empty.
            drain_results();
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                // A small pool of symbols keeps loads and encodes meeting each other.
                sym  = ($urandom_range(99) < 88) ? 8'($urandom_range(7)) : 8'($urandom_range(255));
                code = $urandom;
                len  = '0;
                pick = $urandom_range(99);
                if (pick < 24)
                begin
                    req  = REQ_LOAD;
                    pick = $urandom_range(99);
                    if (pick < 8)
                        len = 6'd0;
                    else if (pick < 62)
                        len = 6'($urandom_range(10, 1));
                    else if (pick < 90)
                        len = 6'($urandom_range(32, 11));
                    else
                        len = 6'($urandom_range(63, 33));
                end
                else if (pick < 80)
                begin
                    req = REQ_ENCODE;
                    len = 6'($urandom_range(63));
                end
                else if (pick < 95)
                begin
                    req = REQ_FLUSH;
                end
                else
                begin
                    req = REQ_UNUSED;
                    len = 6'($urandom_range(63));
                end
                send_request(req, sym, code, len);
                if (!(req == REQ_UNUSED || (req == REQ_LOAD && int'(len) > LEN_LIMIT)))
                    sent++;
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("huffman_code_table_bit_packer_unit regression: pass");
        else
            $display("huffman_code_table_bit_packer_unit regression: fail");
        $finish;
    end

endmodule

### files.f
design/hctbp_pkg.sv
design/hctbp_ram.sv
design/hctbp_shifter.sv
design/huffman_code_table_bit_packer_unit.sv
dv/tb.sv
